/* sv/ceof_pkg.sv */
// Shared types, constants and pixel arithmetic of the color edge outline filter.
package ceof_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam int PIXEL_W     = 32;
	localparam int DIM_W       = 11;
	localparam int STRENGTH_W  = 8;
	localparam int THRESH_W    = 10;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 11;
	localparam int DIFF_W      = 10;

	localparam logic [DIM_W-1:0]      RST_FRAME_WIDTH  = 11'd1024;
	localparam logic [DIM_W-1:0]      RST_FRAME_HEIGHT = 11'd1024;
	localparam logic [STRENGTH_W-1:0] RST_STRENGTH     = 8'd0;
	localparam logic [THRESH_W-1:0]   RST_THRESHOLD    = 10'd72;

	localparam logic [STRENGTH_W-1:0] STRENGTH_CAP = 8'd217;
	localparam logic [STRENGTH_W-1:0] STRENGTH_MIN = 8'd2;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_WIDTH     = 4'd0,
		REG_FRAME_HEIGHT    = 4'd1,
		REG_DARKEN_STRENGTH = 4'd2,
		REG_EDGE_THRESHOLD  = 4'd3
	} cfg_reg_t;

	typedef logic [PIXEL_W-1:0] pixel_t;

	// Sum of absolute differences over the three color bytes.
	function automatic logic [DIFF_W-1:0] byte_diff_sum(input pixel_t a, input pixel_t b);
		logic [7:0]        x;
		logic [7:0]        y;
		logic [DIFF_W-1:0] sum;
		sum = '0;
		for (int k = 0; k < 3; k++) begin
			x = a[8*k +: 8];
			y = b[8*k +: 8];
			sum = sum + DIFF_W'((x > y) ? (x - y) : (y - x));
		end
		return sum;
	endfunction

	// Scales each color byte by (256 - s)/256, truncating, and makes alpha opaque.
	function automatic pixel_t darken_px(input pixel_t px, input logic [STRENGTH_W-1:0] s);
		logic [8:0]  factor;
		logic [16:0] prod;
		pixel_t      res;
		factor = 9'd256 - 9'(s);
		res    = 32'hFF00_0000;
		for (int k = 0; k < 3; k++) begin
			prod = 17'(px[8*k +: 8]) * 17'(factor);
			res[8*k +: 8] = prod[15:8];
		end
		return res;
	endfunction

endpackage

/* sv/ceof_if.sv */
// Handshake channels of the color edge outline filter: pixels, results and configuration.
interface ceof_pix_if;
	logic              valid;
	logic              ready;
	logic              command;
	ceof_pkg::pixel_t  pixel_in;

	modport source(output valid, output command, output pixel_in, input ready);
	modport sink(input valid, input command, input pixel_in, output ready);
endinterface

interface ceof_res_if;
	logic              valid;
	logic              ready;
	ceof_pkg::pixel_t  pixel_out;
	logic              edge_hit;
	logic              frame_last;

	modport source(output valid, output pixel_out, output edge_hit, output frame_last,
		input ready);
	modport sink(input valid, input pixel_out, input edge_hit, input frame_last,
		output ready);
endinterface

interface ceof_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [ceof_pkg::CFG_INDEX_W-1:0]    index;
	logic [ceof_pkg::CFG_DATA_W-1:0]     data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

/* sv/color_edge_outline_filter_unit.sv */
// Once its releasing item is accepted, a pixel passes stage 1 and then the result register.
// One item per cycle unless results stall; each ring copy does one write and one read per cycle.
// The ring lives in three copies (center, right, upper neighbor) so all reads happen in the same cycle.
// Reset clears counters and handshake state and loads the register defaults.
// Ring contents are not cleared by reset; no clearing pass is needed.
module color_edge_outline_filter_unit #(
	parameter int MAX_WIDTH  = ceof_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = ceof_pkg::DEF_MAX_HEIGHT
) (
	input  logic       clk,
	input  logic       arst_n,
	ceof_pix_if.sink   pixels,
	ceof_res_if.source results,
	ceof_cfg_if.sink   cfg
);

	localparam int WW         = $clog2(MAX_WIDTH + 1);
	localparam int HW         = $clog2(MAX_HEIGHT + 1);
	localparam int TW         = WW + HW;
	localparam int CW         = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int COLW       = $clog2(MAX_WIDTH);
	localparam int ROWW       = $clog2(MAX_HEIGHT);
	localparam int RING_DEPTH = 2 * MAX_WIDTH + 1;
	localparam int AW         = $clog2(RING_DEPTH);

	// Configuration registers.
	logic [ceof_pkg::DIM_W-1:0]      frame_width_q;
	logic [ceof_pkg::DIM_W-1:0]      frame_height_q;
	logic [ceof_pkg::STRENGTH_W-1:0] strength_q;
	logic [ceof_pkg::THRESH_W-1:0]   threshold_q;

	// Frame position state.
	logic [CW-1:0]   in_count_q;
	logic [CW-1:0]   out_count_q;
	logic [COLW-1:0] out_col_q;
	logic [ROWW-1:0] out_row_q;
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   ctr_ptr_q;

	ceof_pkg::pixel_t ring_c [RING_DEPTH];
	ceof_pkg::pixel_t ring_r [RING_DEPTH];
	ceof_pkg::pixel_t ring_u [RING_DEPTH];

	// Stage 1: neighborhood of the pixel being released.
	logic             valid_s1;
	ceof_pkg::pixel_t center_s1;
	ceof_pkg::pixel_t left_s1;
	ceof_pkg::pixel_t right_s1;
	ceof_pkg::pixel_t up_s1;
	ceof_pkg::pixel_t down_s1;
	logic             interior_s1;
	logic             bypass_s1;
	logic             last_s1;

	// Result register.
	logic             out_valid_q;
	ceof_pkg::pixel_t out_pixel_q;
	logic             out_hit_q;
	logic             out_last_q;

	logic [31:0]   fw_ext;
	logic [31:0]   fh_ext;
	logic [WW-1:0] eff_w;
	logic [HW-1:0] eff_h;
	logic [TW-1:0] total;
	logic          in_full;
	logic          write_release;
	logic          drain_release;
	logic          frame_done;
	logic          col_wrap;
	logic          interior;
	logic          bypass;
	logic          accept;
	logic          is_pixel;
	logic          wr_en;
	logic          emit;
	logic          out_free;
	logic          move_s1;
	logic [AW-1:0] right_addr;
	logic [AW:0]   up_sum;
	logic [AW-1:0] up_addr;

	logic [ceof_pkg::DIFF_W:0]       dx;
	logic [ceof_pkg::DIFF_W:0]       dy;
	logic [ceof_pkg::DIFF_W:0]       dmax;
	logic [ceof_pkg::STRENGTH_W-1:0] strength_eff;
	logic                            hit;
	ceof_pkg::pixel_t                result_px;

	assign fw_ext = 32'(frame_width_q);
	assign fh_ext = 32'(frame_height_q);

	always_comb begin
		if (fw_ext == 32'd0) begin
			eff_w = WW'(1);
		end else if (fw_ext > 32'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(fw_ext);
		end
		if (fh_ext == 32'd0) begin
			eff_h = HW'(1);
		end else if (fh_ext > 32'(MAX_HEIGHT)) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = HW'(fh_ext);
		end
	end

	assign total   = TW'(eff_w) * TW'(eff_h);
	assign in_full = TW'(in_count_q) >= total;

	// A pixel is released once the pixel one row below it is accepted and written.
	assign write_release = ((TW+1)'(in_count_q) + (TW+1)'(1))
		> ((TW+1)'(out_count_q) + (TW+1)'(eff_w));
	assign drain_release = in_full && (out_count_q < in_count_q);
	assign frame_done    = ((TW+1)'(out_count_q) + (TW+1)'(1)) >= (TW+1)'(total);
	assign col_wrap      = (32'(out_col_q) + 32'd1) >= 32'(eff_w);

	assign interior = (out_row_q != '0) && ((32'(out_row_q) + 32'd1) < 32'(eff_h))
		&& (out_col_q != '0) && ((32'(out_col_q) + 32'd1) < 32'(eff_w));
	assign bypass = (strength_q <= ceof_pkg::STRENGTH_MIN) || (eff_w < WW'(3))
		|| (eff_h < HW'(3));

	assign out_free = !out_valid_q || results.ready;
	assign move_s1  = valid_s1 && out_free;
	assign pixels.ready = !valid_s1 || out_free;

	assign accept   = pixels.valid && pixels.ready;
	assign is_pixel = pixels.command == ceof_pkg::CMD_PIXEL;
	assign wr_en    = accept && is_pixel && !in_full;
	assign emit     = accept && ((is_pixel && !in_full && write_release)
		|| (!is_pixel && drain_release));

	assign right_addr = (ctr_ptr_q == AW'(RING_DEPTH - 1)) ? '0 : ctr_ptr_q + AW'(1);

	always_comb begin
		if ((AW+1)'(ctr_ptr_q) >= (AW+1)'(eff_w)) begin
			up_sum = (AW+1)'(ctr_ptr_q) - (AW+1)'(eff_w);
		end else begin
			up_sum = (AW+1)'(ctr_ptr_q) + (AW+1)'(RING_DEPTH) - (AW+1)'(eff_w);
		end
	end
	assign up_addr = up_sum[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= ceof_pkg::RST_FRAME_WIDTH;
			frame_height_q <= ceof_pkg::RST_FRAME_HEIGHT;
			strength_q     <= ceof_pkg::RST_STRENGTH;
			threshold_q    <= ceof_pkg::RST_THRESHOLD;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				ceof_pkg::REG_FRAME_WIDTH: begin
					frame_width_q <= cfg.data[ceof_pkg::DIM_W-1:0];
				end
				ceof_pkg::REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg.data[ceof_pkg::DIM_W-1:0];
				end
				ceof_pkg::REG_DARKEN_STRENGTH: begin
					strength_q <= cfg.data[ceof_pkg::STRENGTH_W-1:0];
				end
				ceof_pkg::REG_EDGE_THRESHOLD: begin
					threshold_q <= cfg.data[ceof_pkg::THRESH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_count_q  <= '0;
			out_count_q <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			wr_ptr_q    <= '0;
			ctr_ptr_q   <= '0;
		end else begin
			if (wr_en) begin
				in_count_q <= in_count_q + CW'(1);
				wr_ptr_q   <= (wr_ptr_q == AW'(RING_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			// The end of a frame overrides the input count and write pointer advance above.
			if (emit) begin
				if (frame_done) begin
					in_count_q  <= '0;
					out_count_q <= '0;
					out_col_q   <= '0;
					out_row_q   <= '0;
					wr_ptr_q    <= '0;
					ctr_ptr_q   <= '0;
				end else begin
					out_count_q <= out_count_q + CW'(1);
					ctr_ptr_q   <= right_addr;
					if (col_wrap) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + ROWW'(1);
					end else begin
						out_col_q <= out_col_q + COLW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_c[wr_ptr_q] <= pixels.pixel_in;
		end
		if (emit) begin
			center_s1 <= ring_c[ctr_ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_r[wr_ptr_q] <= pixels.pixel_in;
		end
		if (emit) begin
			right_s1 <= ring_r[right_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_u[wr_ptr_q] <= pixels.pixel_in;
		end
		if (emit) begin
			up_s1 <= ring_u[up_addr];
		end
	end

	// The previous center is the left neighbor, since released pixels are consecutive.
	always_ff @(posedge clk) begin
		if (emit) begin
			left_s1     <= center_s1;
			down_s1     <= pixels.pixel_in;
			interior_s1 <= interior;
			bypass_s1   <= bypass;
			last_s1     <= frame_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (emit) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	assign dx = (ceof_pkg::DIFF_W+1)'(ceof_pkg::byte_diff_sum(center_s1, left_s1))
		+ (ceof_pkg::DIFF_W+1)'(ceof_pkg::byte_diff_sum(center_s1, right_s1));
	assign dy = (ceof_pkg::DIFF_W+1)'(ceof_pkg::byte_diff_sum(center_s1, up_s1))
		+ (ceof_pkg::DIFF_W+1)'(ceof_pkg::byte_diff_sum(center_s1, down_s1));
	assign dmax = (dx > dy) ? dx : dy;

	assign strength_eff = (strength_q > ceof_pkg::STRENGTH_CAP) ? ceof_pkg::STRENGTH_CAP
		: strength_q;
	assign hit = !bypass_s1 && interior_s1
		&& (dmax > (ceof_pkg::DIFF_W+1)'(threshold_q));
	assign result_px = hit ? ceof_pkg::darken_px(center_s1, strength_eff) : center_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			out_pixel_q <= result_px;
			out_hit_q   <= hit;
			out_last_q  <= last_s1;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.pixel_out  = out_pixel_q;
	assign results.edge_hit   = out_hit_q;
	assign results.frame_last = out_last_q;

endmodule
